FILE: sv/two_level_round_robin_link_selector_top_macros.svh
// Assertion macros shared by the link selector RTL.
`ifndef TWO_LEVEL_ROUND_ROBIN_LINK_SELECTOR_TOP_MACROS_SVH
`define TWO_LEVEL_ROUND_ROBIN_LINK_SELECTOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define TRR_CHK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define TRR_CHK_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/trrls_pkg.sv
// Types and codes shared by the link selector and its channel interfaces.
package trrls_pkg;

	typedef logic [1:0]  opcode_t;
	typedef logic [2:0]  status_t;
	typedef logic [31:0] ipaddr_t;
	typedef logic [15:0] port_t;
	typedef logic [2:0]  modidx_t;

	localparam opcode_t OP_REGISTER = 2'd0;
	localparam opcode_t OP_ADD      = 2'd1;
	localparam opcode_t OP_DELETE   = 2'd2;
	localparam opcode_t OP_SELECT   = 2'd3;

	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_UNKNOWN = 3'd1;
	localparam status_t ST_NONE    = 3'd2;
	localparam status_t ST_FULL    = 3'd3;
	localparam status_t ST_ABSENT  = 3'd4;

endpackage

FILE: sv/trrls_if.sv
// Request and response channel interfaces of the link selector.
interface trrls_req_if import trrls_pkg::*; ();
	logic    valid;
	logic    ready;
	opcode_t opcode;
	ipaddr_t ip_address;
	port_t   port;
	modidx_t module_index;

	modport source (output valid, output opcode, output ip_address, output port,
		output module_index, input ready);
	modport sink (input valid, input opcode, input ip_address, input port,
		input module_index, output ready);
endinterface

interface trrls_rsp_if import trrls_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	ipaddr_t chosen_address;
	port_t   chosen_port;

	modport source (output valid, output status, output chosen_address,
		output chosen_port, input ready);
	modport sink (input valid, input status, input chosen_address,
		input chosen_port, output ready);
endinterface

FILE: sv/trrls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trrls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: sv/two_level_round_robin_link_selector_top.sv
// Two-level round-robin link selector: address table, port lists and pointers.
//
//   channel  dir  beat contents
//   req      in   opcode, ip_address, port, module_index
//   rsp      out  status, chosen_address, chosen_port (one beat per request)
//
// One request is worked at a time: the request is accepted, the address table is scanned,
// and the opcode is then dispatched. Register and add finish at dispatch, delete scans and
// shifts its port list, and select reads the chosen entry; a select, or a delete that
// empties a list, then searches the slots for the module's next pointer. The completion
// state loads the response register, and it stalls while the previous beat still waits
// on rsp. arst_n clears all counts, pointers and valid flags; the RAMs need no clearing
// because only slots below the fill count and ports below a count are read.
module two_level_round_robin_link_selector_top
	import trrls_pkg::*;
#(
	parameter int MAX_ADDRESSES         = 16,
	parameter int MAX_MODULES           = 8,
	parameter int MAX_PORTS_PER_ADDRESS = 8
) (
	input  logic clk,
	input  logic arst_n,
	trrls_req_if.sink   req,
	trrls_rsp_if.source rsp
);

	`include "two_level_round_robin_link_selector_top_macros.svh"

	localparam int SW  = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1;
	localparam int CW  = $clog2(MAX_ADDRESSES + 2);
	localparam int NW  = $clog2(MAX_PORTS_PER_ADDRESS + 1);
	localparam int PIW = (MAX_PORTS_PER_ADDRESS > 1) ? $clog2(MAX_PORTS_PER_ADDRESS) : 1;
	localparam int MW  = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
	localparam int PD  = MAX_ADDRESSES * MAX_PORTS_PER_ADDRESS;
	localparam int PAW = (PD > 1) ? $clog2(PD) : 1;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_LOOK    = 4'd1;
	localparam logic [3:0] S_DISP    = 4'd2;
	localparam logic [3:0] S_DSCAN   = 4'd3;
	localparam logic [3:0] S_DSHIFT  = 4'd4;
	localparam logic [3:0] S_DFIN    = 4'd5;
	localparam logic [3:0] S_SELCHK  = 4'd6;
	localparam logic [3:0] S_SELWAIT = 4'd7;
	localparam logic [3:0] S_ADV     = 4'd8;
	localparam logic [3:0] S_OUT     = 4'd9;

	logic [3:0]    state_q;
	opcode_t       op_q;
	ipaddr_t       ip_q;
	port_t         port_q;
	modidx_t       mod_q;
	logic [CW-1:0] slots_q;
	logic [CW-1:0] ix_q;
	logic          lk_v_s1;
	logic [SW-1:0] lk_ix_s1;
	logic          found_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] t_q;
	logic [SW-1:0] cand_q;
	logic [MW-1:0] m_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] hit_q;
	logic [PAW-1:0] base_q;
	logic [NW:0]   pix_q;
	logic          pv_s1;
	logic [NW:0]   pix_s1;

	logic [MW-1:0]  owner_q [MAX_ADDRESSES];
	logic [NW-1:0]  cnt_q   [MAX_ADDRESSES];
	logic [PIW-1:0] ptr_q   [MAX_ADDRESSES];
	logic [SW-1:0]  mptr_q  [MAX_MODULES];
	logic           mset_q  [MAX_MODULES];

	status_t res_st_q;
	ipaddr_t res_addr_q;
	port_t   res_port_q;
	logic    ov_q;
	status_t ost_q;
	ipaddr_t oaddr_q;
	port_t   oport_q;

	// Address RAM ports.
	logic          aw_en;
	logic [SW-1:0] aw_addr;
	logic          ar_en;
	logic [SW-1:0] ar_addr;
	ipaddr_t       addr_rd;

	// Port RAM ports.
	logic           pw_en;
	logic [PAW-1:0] pw_addr;
	port_t          pw_data;
	logic           pr_en;
	logic [PAW-1:0] pr_addr;
	port_t          port_rd;

	// One read index into the per-slot registers and one into the per-module registers.
	logic [SW-1:0]  sidx;
	logic [MW-1:0]  midx;
	logic [MW-1:0]  o_rd;
	logic [NW-1:0]  c_rd;
	logic [PIW-1:0] p_rd;
	logic           ms_rd;
	logic [SW-1:0]  mp_rd;

	logic [PIW-1:0] sel_p;
	logic [PIW-1:0] sel_pn;
	logic [PIW-1:0] pdec;
	logic [NW-1:0]  nn;
	logic           elig;
	logic [SW-1:0]  mp_next;
	logic [SW-1:0]  t_next;
	logic [SW-1:0]  cand_next;
	logic [PAW-1:0] slot_base;
	logic [PAW-1:0] t_base;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] cur);
		logic [SW-1:0] nxt;
		if (int'(cur) == MAX_ADDRESSES - 1) begin
			nxt = '0;
		end else begin
			nxt = cur + 1'b1;
		end
		return nxt;
	endfunction

	always_comb begin
		case (state_q)
			S_SELCHK: sidx = t_q;
			S_ADV:    sidx = cand_q;
			default:  sidx = slot_q;
		endcase
	end

	assign o_rd  = owner_q[sidx];
	assign c_rd  = cnt_q[sidx];
	assign p_rd  = ptr_q[sidx];
	assign midx  = (state_q == S_DISP) ? o_rd : m_q;
	assign ms_rd = mset_q[midx];
	assign mp_rd = mptr_q[midx];

	assign slot_base = PAW'(int'(slot_q) * MAX_PORTS_PER_ADDRESS);
	assign t_base    = PAW'(int'(t_q) * MAX_PORTS_PER_ADDRESS);
	assign sel_p     = (NW'(p_rd) >= c_rd) ? '0 : p_rd;
	assign sel_pn    = ((NW'(sel_p) + 1'b1) >= c_rd) ? '0 : sel_p + 1'b1;
	assign nn        = n_q - 1'b1;
	assign pdec      = (NW'(p_rd) > hit_q) ? p_rd - 1'b1 : p_rd;
	assign elig      = (CW'(cand_q) < slots_q) && (o_rd == m_q) && (c_rd != '0);
	assign mp_next   = next_slot(mp_rd);
	assign t_next    = next_slot(t_q);
	assign cand_next = next_slot(cand_q);

	always_comb begin
		aw_en   = 1'b0;
		aw_addr = slots_q[SW-1:0];
		ar_en   = 1'b0;
		ar_addr = ix_q[SW-1:0];
		pw_en   = 1'b0;
		pw_addr = slot_base + PAW'(c_rd);
		pw_data = port_q;
		pr_en   = 1'b0;
		pr_addr = base_q + PAW'(pix_q);
		case (state_q)
			S_LOOK: begin
				ar_en = (ix_q < slots_q);
			end
			S_DISP: begin
				if (op_q == OP_REGISTER) begin
					aw_en = !found_q && (slots_q < CW'(MAX_ADDRESSES))
						&& (int'(mod_q) < MAX_MODULES);
				end else if (op_q == OP_ADD) begin
					pw_en = found_q && (int'(c_rd) < MAX_PORTS_PER_ADDRESS);
				end
			end
			S_DSCAN: begin
				pr_en = (pix_q < {1'b0, n_q});
			end
			S_DSHIFT: begin
				pr_en   = (pix_q < {1'b0, n_q});
				// The beat read last cycle moves down by one entry.
				pw_en   = pv_s1;
				pw_addr = base_q + PAW'(pix_s1) - 1'b1;
				pw_data = port_rd;
			end
			S_SELCHK: begin
				ar_en   = 1'b1;
				ar_addr = t_q;
				pr_en   = 1'b1;
				pr_addr = t_base + PAW'(sel_p);
			end
			default: begin
			end
		endcase
	end

	trrls_ram #(.WIDTH(32), .DEPTH(MAX_ADDRESSES)) u_addr_ram (
		.clk     (clk),
		.wr_en   (aw_en),
		.wr_addr (aw_addr),
		.wr_data (ip_q),
		.rd_en   (ar_en),
		.rd_addr (ar_addr),
		.rd_data (addr_rd)
	);

	trrls_ram #(.WIDTH(16), .DEPTH(PD)) u_port_ram (
		.clk     (clk),
		.wr_en   (pw_en),
		.wr_addr (pw_addr),
		.wr_data (pw_data),
		.rd_en   (pr_en),
		.rd_addr (pr_addr),
		.rd_data (port_rd)
	);

	// Owner needs no reset: it is only read for slots below the fill count.
	always_ff @(posedge clk) begin
		if (state_q == S_DISP && aw_en) begin
			owner_q[slots_q[SW-1:0]] <= MW'(mod_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_REGISTER;
			ip_q       <= '0;
			port_q     <= '0;
			mod_q      <= '0;
			slots_q    <= '0;
			ix_q       <= '0;
			lk_v_s1    <= 1'b0;
			lk_ix_s1   <= '0;
			found_q    <= 1'b0;
			slot_q     <= '0;
			t_q        <= '0;
			cand_q     <= '0;
			m_q        <= '0;
			n_q        <= '0;
			hit_q      <= '0;
			base_q     <= '0;
			pix_q      <= '0;
			pv_s1      <= 1'b0;
			pix_s1     <= '0;
			res_st_q   <= ST_OK;
			res_addr_q <= '0;
			res_port_q <= '0;
			ov_q       <= 1'b0;
			ost_q      <= ST_OK;
			oaddr_q    <= '0;
			oport_q    <= '0;
			for (int i = 0; i < MAX_ADDRESSES; i++) begin
				cnt_q[i] <= '0;
				ptr_q[i] <= '0;
			end
			for (int i = 0; i < MAX_MODULES; i++) begin
				mptr_q[i] <= '0;
				mset_q[i] <= 1'b0;
			end
		end else begin
			// The completion state reloads the response register itself.
			if (ov_q && rsp.ready && state_q != S_OUT) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q       <= req.opcode;
						ip_q       <= req.ip_address;
						port_q     <= req.port;
						mod_q      <= req.module_index;
						ix_q       <= '0;
						lk_v_s1    <= 1'b0;
						found_q    <= 1'b0;
						res_st_q   <= ST_OK;
						res_addr_q <= '0;
						res_port_q <= '0;
						state_q    <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (lk_v_s1 && addr_rd == ip_q) begin
						found_q <= 1'b1;
						slot_q  <= lk_ix_s1;
						state_q <= S_DISP;
					end else if (!lk_v_s1 && ix_q > slots_q) begin
						state_q <= S_DISP;
					end else begin
						lk_v_s1  <= (ix_q < slots_q);
						lk_ix_s1 <= ix_q[SW-1:0];
						if (ix_q <= slots_q) begin
							ix_q <= ix_q + 1'b1;
						end
					end
				end
				S_DISP: begin
					state_q <= S_OUT;
					if (op_q == OP_REGISTER) begin
						if (aw_en) begin
							cnt_q[slots_q[SW-1:0]] <= '0;
							ptr_q[slots_q[SW-1:0]] <= '0;
							slots_q                <= slots_q + 1'b1;
						end else begin
							res_st_q <= ST_FULL;
						end
					end else if (!found_q) begin
						res_st_q <= ST_UNKNOWN;
					end else begin
						case (op_q)
							OP_ADD: begin
								if (int'(c_rd) >= MAX_PORTS_PER_ADDRESS) begin
									res_st_q <= ST_FULL;
								end else begin
									cnt_q[slot_q] <= c_rd + 1'b1;
									if (c_rd == '0) begin
										ptr_q[slot_q] <= '0;
									end
									if (!ms_rd) begin
										mset_q[o_rd] <= 1'b1;
										mptr_q[o_rd] <= slot_q;
									end
								end
							end
							OP_DELETE: begin
								n_q    <= c_rd;
								m_q    <= o_rd;
								base_q <= slot_base;
								pix_q  <= '0;
								pv_s1  <= 1'b0;
								if (c_rd == '0) begin
									res_st_q <= ST_ABSENT;
								end else begin
									state_q <= S_DSCAN;
								end
							end
							default: begin
								if (!ms_rd) begin
									res_st_q <= ST_NONE;
								end else begin
									t_q     <= mp_rd;
									m_q     <= o_rd;
									state_q <= S_SELCHK;
								end
							end
						endcase
					end
				end
				S_DSCAN: begin
					if (pv_s1 && port_rd == port_q) begin
						hit_q   <= NW'(pix_s1);
						pix_q   <= pix_s1 + 1'b1;
						pv_s1   <= 1'b0;
						state_q <= S_DSHIFT;
					end else if (!pv_s1 && pix_q >= {1'b0, n_q}) begin
						res_st_q <= ST_ABSENT;
						state_q  <= S_OUT;
					end else begin
						pv_s1  <= (pix_q < {1'b0, n_q});
						pix_s1 <= pix_q;
						if (pix_q < {1'b0, n_q}) begin
							pix_q <= pix_q + 1'b1;
						end
					end
				end
				S_DSHIFT: begin
					if (!pv_s1 && pix_q >= {1'b0, n_q}) begin
						state_q <= S_DFIN;
					end else begin
						pv_s1  <= (pix_q < {1'b0, n_q});
						pix_s1 <= pix_q;
						if (pix_q < {1'b0, n_q}) begin
							pix_q <= pix_q + 1'b1;
						end
					end
				end
				S_DFIN: begin
					cnt_q[slot_q] <= nn;
					state_q       <= S_OUT;
					if (nn != '0) begin
						ptr_q[slot_q] <= (NW'(pdec) >= nn) ? '0 : pdec;
					end else begin
						ptr_q[slot_q] <= '0;
						// The list went empty, so the owner moves to its next live slot.
						if (ms_rd) begin
							cand_q  <= mp_next;
							ix_q    <= CW'(1);
							state_q <= S_ADV;
						end
					end
				end
				S_SELCHK: begin
					if (CW'(t_q) >= slots_q || c_rd == '0) begin
						res_st_q <= ST_NONE;
						state_q  <= S_OUT;
					end else begin
						ptr_q[t_q] <= sel_pn;
						state_q    <= S_SELWAIT;
					end
				end
				S_SELWAIT: begin
					res_addr_q <= addr_rd;
					res_port_q <= port_rd;
					cand_q     <= t_next;
					ix_q       <= CW'(1);
					state_q    <= S_ADV;
				end
				S_ADV: begin
					// Visits every slot once, ending on the current one.
					if (elig) begin
						mptr_q[m_q] <= cand_q;
						state_q     <= S_OUT;
					end else if (ix_q == CW'(MAX_ADDRESSES)) begin
						mset_q[m_q] <= 1'b0;
						mptr_q[m_q] <= '0;
						state_q     <= S_OUT;
					end else begin
						cand_q <= cand_next;
						ix_q   <= ix_q + 1'b1;
					end
				end
				S_OUT: begin
					if (!ov_q || rsp.ready) begin
						ov_q    <= 1'b1;
						ost_q   <= res_st_q;
						oaddr_q <= res_addr_q;
						oport_q <= res_port_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = ov_q;
	assign rsp.status         = ost_q;
	assign rsp.chosen_address = oaddr_q;
	assign rsp.chosen_port    = oport_q;

	`TRR_CHK_NXT(a_accept_starts_work, req.valid && req.ready, state_q == S_LOOK,
		"accepted request did not start the lookup")
	`TRR_CHK_IMP(a_slots_bounded, 1'b1, slots_q <= CW'(MAX_ADDRESSES),
		"fill count exceeds the address table")
	`TRR_CHK_IMP(a_rsp_from_done, $rose(ov_q), $past(state_q) == S_OUT,
		"response raised outside the completion state")

endmodule

FILE: bench/tb_two_level_round_robin_link_selector_top.sv
// Testbench for the link selector: directed table and random traffic against a predictor.
`timescale 1ns / 100ps

module tb_two_level_round_robin_link_selector_top;
	import trrls_pkg::*;

	localparam int N_ADDR = 16;
	localparam int N_MOD = 8;
	localparam int N_PORT = 8;
	localparam int N_RANDOM = 780;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		status_t st;
		ipaddr_t ad;
		port_t   pt;
	} selection_t;

	typedef struct {
		opcode_t    op;
		ipaddr_t    ip;
		port_t      pt;
		modidx_t    md;
		bit         typed;
		selection_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	trrls_req_if req ();
	trrls_rsp_if rsp ();

	two_level_round_robin_link_selector_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// Shadow copy of the selector state.
	ipaddr_t   tbl_ip   [N_ADDR];
	bit        tbl_used [N_ADDR];
	modidx_t   tbl_own  [N_ADDR];
	int        tbl_fill;
	port_t     port_list[N_ADDR][N_PORT];
	int        port_cnt [N_ADDR];
	int        port_ptr [N_ADDR];
	int        mod_slot [N_MOD];
	bit        mod_valid[N_MOD];

	selection_t  pending_q[$];
	stim_row_t   typed_q[$];
	ipaddr_t     ip_pool[20];
	int          n_sent;
	int          send_idle;
	int          recv_idle;
	bit          hold_off;
	bit          failed;
	int          quiet_cycles;

	function automatic bit slot_has_ports(int s, int m);
		return tbl_used[s] && tbl_own[s] == m && port_cnt[s] > 0;
	endfunction

	function automatic void step_module(int m);
		int cur;
		if (!mod_valid[m])
			return;
		cur = mod_slot[m];
		for (int s = cur + 1; s < N_ADDR; s++) begin
			if (slot_has_ports(s, m)) begin
				mod_slot[m] = s;
				return;
			end
		end
		for (int s = 0; s <= cur; s++) begin
			if (slot_has_ports(s, m)) begin
				mod_slot[m] = s;
				return;
			end
		end
		mod_valid[m] = 0;
		mod_slot[m] = 0;
	endfunction

	function automatic selection_t select_link(opcode_t op, ipaddr_t ip, port_t pt, modidx_t md);
		selection_t r;
		int s;
		int n;
		int i;
		int m;
		int t;
		int p;
		r.st = ST_OK;
		r.ad = '0;
		r.pt = '0;
		s = -1;
		for (int k = 0; k < N_ADDR; k++) begin
			if (s < 0 && tbl_used[k] && tbl_ip[k] == ip)
				s = k;
		end
		if (op == OP_REGISTER) begin
			if (s >= 0 || tbl_fill >= N_ADDR) begin
				r.st = ST_FULL;
			end else begin
				tbl_ip[tbl_fill] = ip;
				tbl_own[tbl_fill] = md;
				tbl_used[tbl_fill] = 1;
				port_cnt[tbl_fill] = 0;
				port_ptr[tbl_fill] = 0;
				tbl_fill++;
			end
		end else if (s < 0) begin
			r.st = ST_UNKNOWN;
		end else if (op == OP_ADD) begin
			n = port_cnt[s];
			if (n >= N_PORT) begin
				r.st = ST_FULL;
			end else begin
				m = tbl_own[s];
				port_list[s][n] = pt;
				port_cnt[s] = n + 1;
				if (n == 0)
					port_ptr[s] = 0;
				if (!mod_valid[m]) begin
					mod_valid[m] = 1;
					mod_slot[m] = s;
				end
			end
		end else if (op == OP_DELETE) begin
			n = port_cnt[s];
			i = 0;
			while (i < n && port_list[s][i] != pt)
				i++;
			if (i >= n) begin
				r.st = ST_ABSENT;
			end else begin
				for (int j = i; j + 1 < n; j++)
					port_list[s][j] = port_list[s][j + 1];
				n--;
				port_cnt[s] = n;
				if (n > 0) begin
					if (port_ptr[s] > i)
						port_ptr[s]--;
					if (port_ptr[s] >= n)
						port_ptr[s] = 0;
				end else begin
					port_ptr[s] = 0;
					step_module(tbl_own[s]);
				end
			end
		end else begin
			m = tbl_own[s];
			t = mod_slot[m];
			if (!mod_valid[m] || !tbl_used[t] || port_cnt[t] == 0) begin
				r.st = ST_NONE;
			end else begin
				p = port_ptr[t];
				if (p >= port_cnt[t])
					p = 0;
				r.ad = tbl_ip[t];
				r.pt = port_list[t][p];
				p++;
				if (p >= port_cnt[t])
					p = 0;
				port_ptr[t] = p;
				step_module(m);
			end
		end
		return r;
	endfunction

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: random back-pressure, or a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_off)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= recv_idle);
	end

	// Predict on every accepted request beat, check every accepted response beat.
	always @(posedge clk) begin
		selection_t want;
		selection_t got;
		stim_row_t row;
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (req.valid && req.ready) begin
				want = select_link(req.opcode, req.ip_address, req.port, req.module_index);
				row = typed_q.pop_front();
				if (row.typed)
					want = row.res;
				pending_q = {pending_q, want};
			end
			if (rsp.valid && rsp.ready) begin
				got.st = rsp.status;
				got.ad = rsp.chosen_address;
				got.pt = rsp.chosen_port;
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected response status=%0d addr=%h port=%h",
						$time, got.st, got.ad, got.pt);
					failed = 1;
				end else begin
					want = pending_q.pop_front();
					if (got.st !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
						failed = 1;
					end
					if (got.ad !== want.ad) begin
						$display("%0t: chosen_address expected %h actual %h",
							$time, want.ad, got.ad);
						failed = 1;
					end
					if (got.pt !== want.pt) begin
						$display("%0t: chosen_port expected %h actual %h",
							$time, want.pt, got.pt);
						failed = 1;
					end
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_beat(stim_row_t row);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		typed_q = {typed_q, row};
		req.valid <= 1'b1;
		req.opcode <= row.op;
		req.ip_address <= row.ip;
		req.port <= row.pt;
		req.module_index <= row.md;
		do
			@(posedge clk);
		while (!req.ready);
		n_sent++;
	endtask

	function automatic stim_row_t rand_row();
		stim_row_t row;
		int pick;
		pick = $urandom_range(99);
		row.op = (pick < 10) ? OP_REGISTER : (pick < 45) ? OP_ADD :
			(pick < 70) ? OP_DELETE : OP_SELECT;
		row.ip = ($urandom_range(19) < 19) ? ip_pool[$urandom_range(19)] : $urandom;
		row.pt = ($urandom_range(9) < 8) ? port_t'($urandom_range(5)) : port_t'($urandom);
		row.md = modidx_t'($urandom_range(N_MOD - 1));
		row.typed = 0;
		row.res = '{ST_OK, '0, '0};
		return row;
	endfunction

	// Receiver holds off for a long stretch while the sender keeps offering beats.
	initial begin
		hold_off = 0;
		wait (n_sent >= 120);
		@(posedge clk);
		hold_off <= 1;
		repeat (400) @(posedge clk);
		hold_off <= 0;
	end

	initial begin
		stim_row_t directed[$];
		directed = '{
			'{OP_SELECT,   32'h0000_0000, 16'h0000, 3'd0, 1, '{ST_UNKNOWN, '0, '0}},
			'{OP_ADD,      32'h0000_0000, 16'h0001, 3'd0, 1, '{ST_UNKNOWN, '0, '0}},
			'{OP_DELETE,   32'h0000_0000, 16'h0001, 3'd0, 1, '{ST_UNKNOWN, '0, '0}},
			'{OP_REGISTER, 32'h0000_0000, 16'h0000, 3'd0, 1, '{ST_OK, '0, '0}},
			'{OP_REGISTER, 32'h0000_0000, 16'hFFFF, 3'd5, 1, '{ST_FULL, '0, '0}},
			'{OP_SELECT,   32'h0000_0000, 16'h0000, 3'd0, 1, '{ST_NONE, '0, '0}},
			'{OP_DELETE,   32'h0000_0000, 16'h0005, 3'd0, 1, '{ST_ABSENT, '0, '0}},
			'{OP_ADD,      32'h0000_0000, 16'h0000, 3'd0, 1, '{ST_OK, '0, '0}},
			'{OP_ADD,      32'h0000_0000, 16'hFFFF, 3'd0, 1, '{ST_OK, '0, '0}},
			'{OP_ADD,      32'h0000_0000, 16'hFFFF, 3'd0, 1, '{ST_OK, '0, '0}},
			'{OP_SELECT,   32'h0000_0000, 16'h0000, 3'd0, 1, '{ST_OK, 32'h0, 16'h0}},
			'{OP_REGISTER, 32'hFFFF_FFFF, 16'h0000, 3'd7, 1, '{ST_OK, '0, '0}},
			'{OP_ADD,      32'hFFFF_FFFF, 16'h1234, 3'd0, 1, '{ST_OK, '0, '0}},
			'{OP_SELECT,   32'hFFFF_FFFF, 16'h0000, 3'd0, 1,
				'{ST_OK, 32'hFFFF_FFFF, 16'h1234}},
			'{OP_REGISTER, 32'h0000_0001, 16'h0000, 3'd0, 0, '{ST_OK, '0, '0}},
			'{OP_ADD,      32'h0000_0001, 16'h0007, 3'd0, 0, '{ST_OK, '0, '0}},
			'{OP_DELETE,   32'h0000_0000, 16'hFFFF, 3'd0, 0, '{ST_OK, '0, '0}},
			'{OP_SELECT,   32'h0000_0000, 16'h0000, 3'd0, 0, '{ST_OK, '0, '0}},
			'{OP_SELECT,   32'h0000_0001, 16'h0000, 3'd0, 0, '{ST_OK, '0, '0}},
			'{OP_DELETE,   32'h0000_0001, 16'h0007, 3'd0, 0, '{ST_OK, '0, '0}},
			'{OP_SELECT,   32'h0000_0000, 16'h0000, 3'd0, 0, '{ST_OK, '0, '0}},
			'{OP_DELETE,   32'hFFFF_FFFF, 16'h1234, 3'd0, 0, '{ST_OK, '0, '0}},
			'{OP_SELECT,   32'hFFFF_FFFF, 16'h0000, 3'd0, 1, '{ST_NONE, '0, '0}}
		};
		failed = 0;
		quiet_cycles = 0;
		n_sent = 0;
		send_idle = 17;
		recv_idle = 70;
		tbl_fill = 0;
		for (int k = 0; k < N_ADDR; k++) begin
			tbl_used[k] = 0;
			port_cnt[k] = 0;
			port_ptr[k] = 0;
		end
		for (int k = 0; k < N_MOD; k++) begin
			mod_slot[k] = 0;
			mod_valid[k] = 0;
		end
		ip_pool[0] = 32'h0000_0000;
		ip_pool[1] = 32'hFFFF_FFFF;
		ip_pool[2] = 32'h0000_0001;
		for (int k = 3; k < 20; k++)
			ip_pool[k] = $urandom;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = OP_REGISTER;
		req.ip_address = '0;
		req.port = '0;
		req.module_index = '0;
		rsp.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_beat(directed[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				// Let the block drain completely before the next phase.
				req.valid <= 1'b0;
				wait (pending_q.size() == 0 && typed_q.size() == 0);
				@(posedge clk);
				send_idle = 70;
				recv_idle = 17;
			end else if (i == 2 * N_RANDOM / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			send_beat(rand_row());
		end
		req.valid <= 1'b0;
		wait (pending_q.size() == 0 && typed_q.size() == 0);
		repeat (100) @(posedge clk);
		if (!failed && pending_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
